// ===== sv/ptmsrn_pkg.sv =====
// Shared types and constants for the modification site range narrowing block.
`timescale 1ns / 1ps

package ptmsrn_pkg;

  localparam int POS_W   = 13;
  localparam int TOL_W   = 23;
  localparam int MASS_W  = 38;
  localparam int SHIFT_W = 31;
  localparam int INT_W   = 32;
  localparam int HALF_W  = MASS_W / 2;
  localparam int PP_W    = HALF_W + TOL_W;
  localparam int PROD_W  = MASS_W + TOL_W;
  localparam int TOLQ_W  = PROD_W - 32;
  localparam int DIFF_W  = MASS_W + 1;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(42950);

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_FRAG = 1'b1;

  typedef enum logic [2:0] {
    OUT_LOADED    = 3'd0,
    OUT_NOT_BRKT  = 3'd1,
    OUT_AMBIGUOUS = 3'd2,
    OUT_TIGHTENED = 3'd3,
    OUT_OVERRIDE  = 3'd4,
    OUT_REJECTED  = 3'd5
  } outcome_t;

  typedef struct packed {
    logic                      action;
    logic                      prefix_ion;
    logic [POS_W-1:0]          pos;
    logic [POS_W-1:0]          start;
    logic [POS_W-1:0]          stop;
    logic signed [SHIFT_W-1:0] shift;
    logic [INT_W-1:0]          intensity;
  } item_t;

  typedef struct packed {
    logic b;
    logic c;
  } adv_t;

endpackage

// ===== sv/ptm_site_range_narrowing.sv =====
// Top level: candidate site range narrowing for one modification.
// Throughput: one word per cycle unless the output stalls. Words pass the input, partial
// product and tolerance registers; range, supports and shift update in the last stage and
// feed the next word directly; the tolerance multiply is split into two partial products.
// Reset (rst, synchronous): empties the pipeline, clears range, supports and
// shift, and loads both tolerance registers with 42950.
`timescale 1ns / 1ps

module ptm_site_range_narrowing import ptmsrn_pkg::*; #(
  parameter int MAX_LEN = 4096
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // range_start_in[12:0], range_end_in[25:13], mod_shift[56:26], prefix_ion[57],
  // cover_pos[70:58], base_mass[108:71], obs_mass[146:109],
  // intensity[178:147], frag_level[179], zero pad
  input  logic [183:0] s_tdata,
  // action[0]
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // range_low[12:0], range_high[25:13], outcome[28:26], zero pad
  output logic [31:0]  m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] v);
    clamp_pos = (32'(v) > MAX_LEN) ? POS_W'(MAX_LEN) : v;
  endfunction

  logic [TOL_W-1:0] tol_level2;
  logic [TOL_W-1:0] tol_level3;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'(tol_level3) : 32'(tol_level2);

  always_ff @(posedge clk) begin
    if (rst) begin
      tol_level2 <= TOL_RESET;
      tol_level3 <= TOL_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) tol_level3 <= pwdata[TOL_W-1:0];
      else          tol_level2 <= pwdata[TOL_W-1:0];
    end
  end

  // pipeline control
  logic v1, v2, v3;
  logic adv1, adv2, adv3, adv_out;
  adv_t adv;

  assign adv_out  = !m_tvalid || m_tready;
  assign adv3     = adv_out || !v3;
  assign adv2     = adv3 || !v2;
  assign adv1     = adv2 || !v1;
  assign s_tready = adv1;
  assign adv.b    = adv2;
  assign adv.c    = adv3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (adv1)    v1       <= s_tvalid;
      if (adv2)    v2       <= v1;
      if (adv3)    v3       <= v2;
      if (adv_out) m_tvalid <= v3;
    end
  end

  // input word
  item_t             item1, item2, item3;
  logic [MASS_W-1:0] base1, obs1;
  logic              level1;

  always_ff @(posedge clk) begin
    if (adv1) begin
      item1.action     <= s_tuser;
      item1.start      <= clamp_pos(s_tdata[12:0]);
      item1.stop       <= clamp_pos(s_tdata[25:13]);
      item1.shift      <= $signed(s_tdata[56:26]);
      item1.prefix_ion <= s_tdata[57];
      item1.pos        <= clamp_pos(s_tdata[70:58]);
      base1            <= s_tdata[108:71];
      obs1             <= s_tdata[146:109];
      item1.intensity  <= s_tdata[178:147];
      level1           <= s_tdata[179];
    end
    if (adv2) item2 <= item1;
    if (adv3) item3 <= item2;
  end

  logic [TOLQ_W-1:0]        tol3;
  logic signed [DIFF_W-1:0] diff3;
  logic [DIFF_W-1:0]        diff_mag3;

  ptmsrn_mass u_mass (
    .clk       (clk),
    .adv       (adv),
    .obs_mass  (obs1),
    .base_mass (base1),
    .tol_reg   (level1 ? tol_level3 : tol_level2),
    .tol       (tol3),
    .diff      (diff3),
    .diff_mag  (diff_mag3)
  );

  // range state
  logic [POS_W-1:0]          range_low, range_high;
  logic [INT_W-1:0]          low_support, high_support;
  logic signed [SHIFT_W-1:0] shift_reg;
  outcome_t                  outcome;

  logic [POS_W-1:0]          range_low_next, range_high_next;
  logic [INT_W-1:0]          low_support_next, high_support_next;
  logic signed [SHIFT_W-1:0] shift_reg_next;
  outcome_t                  outcome_next;

  logic signed [DIFF_W:0] diff_mod;
  logic [DIFF_W:0]        diff_mod_mag;
  logic                   with_m, without_m, brackets, move_up;
  logic [POS_W:0]         mv, low_x, high_x;

  assign diff_mod     = $signed({diff3[DIFF_W-1], diff3}) - (DIFF_W+1)'(shift_reg);
  assign diff_mod_mag = diff_mod[DIFF_W] ? (DIFF_W+1)'(-diff_mod) : (DIFF_W+1)'(diff_mod);
  assign with_m       = diff_mod_mag <= (DIFF_W+1)'(tol3);
  assign without_m    = diff_mag3 <= DIFF_W'(tol3);
  assign brackets     = item3.prefix_ion ? (range_low <= item3.pos && item3.pos < range_high)
                                         : (range_low < item3.pos && item3.pos <= range_high);
  assign move_up      = item3.prefix_ion == with_m;
  assign low_x        = {1'b0, range_low};
  assign high_x       = {1'b0, range_high};

  always_comb begin
    if (with_m)                mv = {1'b0, item3.pos};
    else if (item3.prefix_ion) mv = {1'b0, item3.pos} + (POS_W+1)'(1);
    else                       mv = {1'b0, item3.pos} - (POS_W+1)'(1);
  end

  always_comb begin
    range_low_next    = range_low;
    range_high_next   = range_high;
    low_support_next  = low_support;
    high_support_next = high_support;
    shift_reg_next    = shift_reg;
    outcome_next      = OUT_NOT_BRKT;
    if (item3.action == ACT_LOAD) begin
      range_low_next    = item3.start;
      range_high_next   = item3.stop;
      low_support_next  = '0;
      high_support_next = '0;
      shift_reg_next    = item3.shift;
      outcome_next      = OUT_LOADED;
    end else if (!brackets) begin
      outcome_next = OUT_NOT_BRKT;
    end else if (with_m == without_m) begin
      outcome_next = OUT_AMBIGUOUS;
    end else if (move_up) begin
      if (mv >= high_x) begin
        outcome_next = OUT_NOT_BRKT;
      end else if (mv >= low_x) begin
        range_high_next   = mv[POS_W-1:0];
        high_support_next = item3.intensity;
        outcome_next      = OUT_TIGHTENED;
      end else if (item3.intensity > low_support) begin
        range_low_next    = mv[POS_W-1:0];
        range_high_next   = mv[POS_W-1:0];
        low_support_next  = item3.intensity;
        high_support_next = item3.intensity;
        outcome_next      = OUT_OVERRIDE;
      end else begin
        outcome_next = OUT_REJECTED;
      end
    end else begin
      if (mv <= low_x) begin
        outcome_next = OUT_NOT_BRKT;
      end else if (mv <= high_x) begin
        range_low_next   = mv[POS_W-1:0];
        low_support_next = item3.intensity;
        outcome_next     = OUT_TIGHTENED;
      end else if (item3.intensity > high_support) begin
        range_low_next    = mv[POS_W-1:0];
        range_high_next   = mv[POS_W-1:0];
        low_support_next  = item3.intensity;
        high_support_next = item3.intensity;
        outcome_next      = OUT_OVERRIDE;
      end else begin
        outcome_next = OUT_REJECTED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low    <= '0;
      range_high   <= '0;
      low_support  <= '0;
      high_support <= '0;
      shift_reg    <= '0;
    end else if (adv_out && v3) begin
      range_low    <= range_low_next;
      range_high   <= range_high_next;
      low_support  <= low_support_next;
      high_support <= high_support_next;
      shift_reg    <= shift_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && v3) outcome <= outcome_next;
  end

  // the result word mirrors the state, which changes only when a result loads
  assign m_tdata = {3'b000, outcome, range_high, range_low};

`ifndef NO_ASSERTIONS
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled while output side can drain");

  a_no_conflict: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (outcome != OUT_OVERRIDE && outcome != OUT_REJECTED))
    else $error("conflict outcome from a bracketing fragment");

  a_range_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (32'(range_low) <= MAX_LEN && 32'(range_high) <= MAX_LEN))
    else $error("range boundary beyond maximum length");

  a_tight_order: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && outcome == OUT_TIGHTENED) |-> range_low <= range_high)
    else $error("tightened range is inverted");
`endif

endmodule

// ===== sv/ptmsrn_mass.sv =====
// Tolerance product and observed minus base mass difference, two stages.
`timescale 1ns / 1ps

module ptmsrn_mass import ptmsrn_pkg::*; (
  input  logic                     clk,
  input  adv_t                     adv,
  input  logic [MASS_W-1:0]        obs_mass,
  input  logic [MASS_W-1:0]        base_mass,
  input  logic [TOL_W-1:0]         tol_reg,
  output logic [TOLQ_W-1:0]        tol,
  output logic signed [DIFF_W-1:0] diff,
  output logic [DIFF_W-1:0]        diff_mag
);

  logic [PP_W-1:0]          pp_hi;
  logic [PP_W-1:0]          pp_lo;
  logic signed [DIFF_W-1:0] diff_b;
  logic [PROD_W-1:0]        prod;

  always_ff @(posedge clk) begin
    if (adv.b) begin
      pp_hi  <= PP_W'(obs_mass[MASS_W-1:HALF_W]) * PP_W'(tol_reg);
      pp_lo  <= PP_W'(obs_mass[HALF_W-1:0]) * PP_W'(tol_reg);
      diff_b <= $signed({1'b0, obs_mass}) - $signed({1'b0, base_mass});
    end
  end

  assign prod = {pp_hi, {HALF_W{1'b0}}} + PROD_W'(pp_lo);

  always_ff @(posedge clk) begin
    if (adv.c) begin
      tol      <= prod[PROD_W-1:32];
      diff     <= diff_b;
      diff_mag <= diff_b[DIFF_W-1] ? DIFF_W'(-diff_b) : DIFF_W'(diff_b);
    end
  end

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the modification site range narrowing block.
`timescale 1ns / 1ps

module testbench import ptmsrn_pkg::*; ();

  localparam int          MAX_LEN  = 4096;
  localparam logic [2:0]  REG_TOL2 = 3'd0;
  localparam logic [2:0]  REG_TOL3 = 3'd4;
  localparam longint      MASS_MAX = 64'h3F_FFFF_FFFF;

  typedef struct {
    logic                      action;
    logic [POS_W-1:0]          start;
    logic [POS_W-1:0]          stop;
    logic signed [SHIFT_W-1:0] shift;
    logic                      prefix;
    logic [POS_W-1:0]          pos;
    logic [MASS_W-1:0]         base;
    logic [MASS_W-1:0]         obs;
    logic [INT_W-1:0]          inten;
    logic                      level;
  } site_word_t;

  typedef struct {
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
    outcome_t         oc;
  } site_result_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [183:0] s_tdata;
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [31:0]  m_tdata;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  // mirror of the block state
  logic [POS_W-1:0] cur_lo, cur_hi;
  logic [INT_W-1:0] sup_lo, sup_hi;
  longint           cur_shift;
  logic [TOL_W-1:0] tol2, tol3;

  site_result_t range_results_q[$];
  int           errors;
  bit           src_gaps;
  bit           sink_gaps;
  bit           hold_req;

  ptm_site_range_narrowing #(.MAX_LEN(MAX_LEN)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 600000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic logic [POS_W-1:0] sat_pos(input logic [POS_W-1:0] v);
    return (v > MAX_LEN) ? POS_W'(MAX_LEN) : v;
  endfunction

  function automatic bit mass_hit(input longint obs, input longint tgt, input longint tol);
    longint d;
    d = obs - tgt;
    if (d < 0) d = -d;
    return d <= tol;
  endfunction

  function automatic outcome_t move_high(input logic [POS_W:0] nu, input logic [INT_W-1:0] w);
    if (nu >= cur_hi) return OUT_NOT_BRKT;
    if (nu >= cur_lo) begin
      cur_hi = nu[POS_W-1:0];
      sup_hi = w;
      return OUT_TIGHTENED;
    end
    if (w > sup_lo) begin
      cur_lo = nu[POS_W-1:0];
      cur_hi = nu[POS_W-1:0];
      sup_lo = w;
      sup_hi = w;
      return OUT_OVERRIDE;
    end
    return OUT_REJECTED;
  endfunction

  function automatic outcome_t move_low(input logic [POS_W:0] nl, input logic [INT_W-1:0] w);
    if (nl <= cur_lo) return OUT_NOT_BRKT;
    if (nl <= cur_hi) begin
      cur_lo = nl[POS_W-1:0];
      sup_lo = w;
      return OUT_TIGHTENED;
    end
    if (w > sup_hi) begin
      cur_lo = nl[POS_W-1:0];
      cur_hi = nl[POS_W-1:0];
      sup_lo = w;
      sup_hi = w;
      return OUT_OVERRIDE;
    end
    return OUT_REJECTED;
  endfunction

  task automatic predict_narrowing(input site_word_t w);
    logic [POS_W-1:0] pos;
    logic [63:0]      prod;
    longint           tol, obs, base;
    bit               with_m, without_m, brk;
    site_result_t     r;
    if (w.action == ACT_LOAD) begin
      cur_lo    = sat_pos(w.start);
      cur_hi    = sat_pos(w.stop);
      sup_lo    = '0;
      sup_hi    = '0;
      cur_shift = longint'(w.shift);
      r.oc      = OUT_LOADED;
    end else begin
      pos  = sat_pos(w.pos);
      prod = 64'(w.obs) * 64'(w.level ? tol3 : tol2);
      tol  = longint'(prod >> 32);
      obs  = longint'({26'b0, w.obs});
      base = longint'({26'b0, w.base});
      brk  = w.prefix ? (cur_lo <= pos && pos < cur_hi) : (cur_lo < pos && pos <= cur_hi);
      if (!brk) begin
        r.oc = OUT_NOT_BRKT;
      end else begin
        with_m    = mass_hit(obs, base + cur_shift, tol);
        without_m = mass_hit(obs, base, tol);
        if (with_m == without_m) r.oc = OUT_AMBIGUOUS;
        else if (with_m) r.oc = w.prefix ? move_high({1'b0, pos}, w.inten)
                                         : move_low({1'b0, pos}, w.inten);
        else r.oc = w.prefix ? move_low({1'b0, pos} + 1'b1, w.inten)
                             : move_high({1'b0, pos} - 1'b1, w.inten);
      end
    end
    r.lo = cur_lo;
    r.hi = cur_hi;
    range_results_q.insert(range_results_q.size(), r);
  endtask

  task automatic send_word(input site_word_t w);
    s_tvalid <= 1'b1;
    s_tuser  <= w.action;
    s_tdata  <= {4'b0, w.level, w.inten, w.obs, w.base, w.pos, w.prefix,
                 w.shift, w.stop, w.start};
    do @(posedge clk); while (!s_tready);
    predict_narrowing(w);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (range_results_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == REG_TOL2) tol2 = data[TOL_W-1:0];
    else tol3 = data[TOL_W-1:0];
    @(posedge clk);
  endtask

  task automatic apb_check(input logic [2:0] addr, input logic [TOL_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {9'b0, want}) flag_mismatch("prdata", prdata, want);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_tolerances(input logic [31:0] t2, input logic [31:0] t3);
    apb_write(REG_TOL2, t2);
    apb_write(REG_TOL3, t3);
    apb_check(REG_TOL2, tol2);
    apb_check(REG_TOL3, tol3);
  endtask

  function automatic site_word_t load_word(input logic [POS_W-1:0] start,
                                           input logic [POS_W-1:0] stop,
                                           input logic [SHIFT_W-1:0] shift);
    site_word_t w;
    w.action = ACT_LOAD;
    w.start  = start;
    w.stop   = stop;
    w.shift  = shift;
    w.prefix = 1'($urandom);
    w.pos    = POS_W'($urandom);
    w.base   = MASS_W'({$urandom, $urandom});
    w.obs    = MASS_W'({$urandom, $urandom});
    w.inten  = $urandom;
    w.level  = 1'($urandom);
    return w;
  endfunction

  function automatic site_word_t frag_word(input logic prefix, input logic [POS_W-1:0] pos,
                                           input logic [MASS_W-1:0] base, input logic with_mod,
                                           input longint delta, input logic level,
                                           input logic [INT_W-1:0] inten);
    site_word_t w;
    longint     o;
    w        = load_word(POS_W'($urandom), POS_W'($urandom), SHIFT_W'($urandom));
    w.action = ACT_FRAG;
    w.prefix = prefix;
    w.pos    = pos;
    w.base   = base;
    o = longint'({26'b0, base}) + (with_mod ? cur_shift : 0) + delta;
    if (o < 0) o = 0;
    if (o > MASS_MAX) o = MASS_MAX;
    w.obs    = o[MASS_W-1:0];
    w.inten  = inten;
    w.level  = level;
    return w;
  endfunction

  function automatic site_word_t rand_fragment();
    logic              prefix, with_mod, lvl;
    logic [POS_W-1:0]  pos;
    logic [MASS_W-1:0] base;
    logic [INT_W-1:0]  inten;
    longint            tgt, delta;
    logic [63:0]       est;
    site_word_t        w;
    prefix   = 1'($urandom);
    with_mod = 1'($urandom);
    lvl      = 1'($urandom);
    if (cur_lo < cur_hi && $urandom_range(0, 7) != 0)
      pos = prefix ? POS_W'($urandom_range(cur_lo, cur_hi - 1))
                   : POS_W'($urandom_range(cur_lo + 1, cur_hi));
    else
      pos = POS_W'($urandom);
    base = MASS_W'({$urandom, $urandom});
    base = base >> $urandom_range(0, 30);
    tgt  = longint'({26'b0, base}) + (with_mod ? cur_shift : 0);
    if (tgt < 0) tgt = 0;
    est  = (64'(tgt) * 64'(lvl ? tol3 : tol2)) >> 32;
    case ($urandom_range(0, 5))
      0: delta = longint'(est) + 1;
      1: delta = longint'(est);
      default: delta = longint'($urandom_range(0, 32'(2 * est))) - longint'(est);
    endcase
    if ($urandom_range(0, 1)) delta = -delta;
    case ($urandom_range(0, 7))
      0: inten = '0;
      1: inten = '1;
      default: inten = $urandom;
    endcase
    w = frag_word(prefix, pos, base, with_mod, delta, lvl, inten);
    if ($urandom_range(0, 15) == 0) w.obs = MASS_W'({$urandom, $urandom});
    return w;
  endfunction

  function automatic site_word_t rand_load();
    logic [POS_W-1:0]   start, stop;
    logic [SHIFT_W-1:0] sh;
    int                 mag;
    if ($urandom_range(0, 5) == 0) begin
      start = POS_W'($urandom);
      stop  = POS_W'($urandom);
    end else begin
      start = POS_W'($urandom_range(1, 4000));
      stop  = POS_W'($urandom_range(start + 1, MAX_LEN));
    end
    case ($urandom_range(0, 7))
      0: sh = SHIFT_W'($urandom);
      1: sh = SHIFT_W'(int'($urandom_range(0, 40)) - 20);
      2: sh = $urandom_range(0, 1) ? 31'h3FFF_FFFF : 31'h4000_0000;
      default: begin
        mag = $urandom_range(4096, 1 << 28);
        sh  = $urandom_range(0, 1) ? SHIFT_W'(mag) : SHIFT_W'(-mag);
      end
    endcase
    return load_word(start, stop, sh);
  endfunction

  task automatic run_random(input int n);
    repeat (n) begin
      if (cur_lo >= cur_hi || $urandom_range(0, 11) == 0) send_word(rand_load());
      else send_word(rand_fragment());
    end
  endtask

  task automatic test_directed_cases();
    // before any load
    send_word(frag_word(1'b1, 13'd5, 38'd1 << 30, 1'b1, 64'sd0, 1'b0, 32'd9));
    send_word(load_word(13'd1, 13'h1FFF, 31'h3FFF_FFFF));
    send_word(frag_word(1'b1, 13'd4000, 38'd1 << 30, 1'b1, 64'sd0, 1'b0, '1));
    send_word(frag_word(1'b0, 13'd2, 38'd1 << 30, 1'b1, 64'sd0, 1'b1, '0));
    send_word(frag_word(1'b1, 13'd3000, 38'd1 << 31, 1'b0, 64'sd0, 1'b0, 32'd100));
    send_word(frag_word(1'b0, 13'd3500, 38'd1 << 31, 1'b0, 64'sd0, 1'b1, 32'd200));
    // neither mass
    send_word(frag_word(1'b1, 13'd3200, 38'd1 << 32, 1'b0, 64'sd1 << 34, 1'b0, 32'd5));
    // saturated position
    send_word(frag_word(1'b1, 13'h1FFF, 38'd1 << 30, 1'b1, 64'sd0, 1'b0, 32'd1));
    send_word(frag_word(1'b0, 13'd3400, 38'd0, 1'b0, 64'sd0, 1'b0, 32'd7));
    // both masses match
    send_word(load_word(13'd100, 13'd200, 31'd0));
    send_word(frag_word(1'b1, 13'd150, 38'd1 << 33, 1'b0, 64'sd0, 1'b1, 32'd3));
    // empty range
    send_word(load_word(13'h1FFF, 13'd0, 31'd77));
    send_word(frag_word(1'b0, 13'd1, 38'd1 << 30, 1'b0, 64'sd0, 1'b0, 32'd3));
    send_word(load_word(13'd10, 13'd4096, 31'h4000_0000));
    send_word(frag_word(1'b1, 13'd4095, 38'h3F_FFFF_FFFF, 1'b1, 64'sd0, 1'b1, 32'd50));
    send_word(frag_word(1'b0, 13'd4095, 38'h3F_FFFF_FFFF, 1'b0, 64'sd0, 1'b0, 32'd60));
    send_word(frag_word(1'b1, 13'd10, 38'd1 << 35, 1'b1, 64'sd0, 1'b1, 32'd70));
    // collapsed range
    send_word(frag_word(1'b0, 13'd10, 38'd1 << 35, 1'b1, 64'sd0, 1'b1, 32'd70));
    send_word(load_word(13'd1, 13'd2, 31'd12345));
    send_word(frag_word(1'b1, 13'd1, 38'd1 << 29, 1'b0, 64'sd0, 1'b0, 32'd11));
    send_word(load_word(13'd0, 13'd4096, 31'h0000_1000));
    // position zero
    send_word(frag_word(1'b1, 13'd0, 38'd1 << 29, 1'b1, 64'sd0, 1'b0, 32'd12));
    wait_drained();
  endtask

  task automatic test_backpressure_fill();
    src_gaps = 1'b0;
    hold_req = 1'b1;
    run_random(40);
    src_gaps = 1'b1;
    wait_drained();
    run_random(40);
    wait_drained();
  endtask

  task automatic test_tolerance_sweep();
    set_tolerances(32'd0, 32'd4194304);
    run_random(200);
    wait_drained();
    set_tolerances(32'h007F_FFFF, 32'd0);
    run_random(200);
    wait_drained();
    set_tolerances(32'd4194304, 32'hFF80_0000 | 32'd42950);
    run_random(200);
    wait_drained();
    set_tolerances($urandom, $urandom);
    run_random(200);
    wait_drained();
    set_tolerances(32'd1000, 32'd300000);
    run_random(200);
    wait_drained();
    set_tolerances(32'd42950, 32'd42950);
    run_random(200);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    run_random(300);
    wait_drained();
  endtask

  task automatic test_no_idle_tail();
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    run_random(200);
    wait_drained();
  endtask

  // receiver side: random stalls and one long hold-off on request
  initial begin : sink
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    site_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (range_results_q.size() == 0) begin
        flag_mismatch("unexpected word", m_tdata, 0);
      end else begin
        want = range_results_q.pop_front();
        if (m_tdata[12:0] !== want.lo) flag_mismatch("range_low", m_tdata[12:0], want.lo);
        if (m_tdata[25:13] !== want.hi) flag_mismatch("range_high", m_tdata[25:13], want.hi);
        if (m_tdata[28:26] !== want.oc) flag_mismatch("outcome", m_tdata[28:26], want.oc);
      end
    end
  end

  initial begin
    errors    = 0;
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    hold_req  = 1'b0;
    cur_lo    = '0;
    cur_hi    = '0;
    sup_lo    = '0;
    sup_hi    = '0;
    cur_shift = 0;
    tol2      = TOL_RESET;
    tol3      = TOL_RESET;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apb_check(REG_TOL2, TOL_RESET);
    apb_check(REG_TOL3, TOL_RESET);
    test_directed_cases();
    test_backpressure_fill();
    test_tolerance_sweep();
    test_random_traffic();
    test_no_idle_tail();
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ptmsrn_pkg.sv
sv/ptmsrn_mass.sv
sv/ptm_site_range_narrowing.sv
bench/testbench.sv
